>>> hdl/ikey_pkg.sv
// ----------------------------------------------------------------------------
// ikey_pkg
// Shared types and codes for the iambic Morse keyer.
// ----------------------------------------------------------------------------
package ikey_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_t;

  localparam int unsigned UNITS_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TX_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TUNE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_UNITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAH_UNITS = 3'd3;

  typedef struct packed {
    logic               tx_enable;
    logic               tune_mode;
    logic [UNITS_W-1:0] dit_units;
    logic [UNITS_W-1:0] dah_units;
  } cfg_t;

  typedef struct packed {
    logic qsk_restart;
    logic iambic_active;
    logic tr_transmit;
    logic sidetone_on;
    logic key_out;
  } result_t;

endpackage

>>> hdl/ikey_core.sv
// ----------------------------------------------------------------------------
// ikey_core
// Element sequencer: advances the keyer state by one tick per accepted request
// and produces that tick's result.
// ----------------------------------------------------------------------------
module ikey_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    dit_pressed,
  input  logic                    dah_pressed,
  input  ikey_pkg::cfg_t          cfg,
  output ikey_pkg::result_t       res
);

  ikey_pkg::phase_t                 phase_r, phase_nxt;
  logic [ikey_pkg::UNITS_W-1:0]     units_r, units_nxt;
  logic                             is_dah_r, is_dah_nxt;
  logic                             sq_r, sq_nxt;
  logic                             keyed_r, keyed_nxt;

  logic                             tune;
  logic                             any_press;
  logic                             both_press;
  logic                             start_dah;
  logic [ikey_pkg::UNITS_W-1:0]     len_raw;
  logic [ikey_pkg::UNITS_W-1:0]     len;
  logic [ikey_pkg::UNITS_W-1:0]     units_dec;
  logic                             mark;
  logic                             key;

  assign tune       = cfg.tx_enable & cfg.tune_mode;
  assign any_press  = dit_pressed | dah_pressed;
  assign both_press = dit_pressed & dah_pressed;
  assign start_dah  = both_press ? ~is_dah_r : dah_pressed;
  assign len_raw    = start_dah ? cfg.dah_units : cfg.dit_units;
  assign len        = (len_raw == '0) ? ikey_pkg::UNITS_W'(1) : len_raw;
  assign units_dec  = (units_r != '0) ? units_r - ikey_pkg::UNITS_W'(1) : units_r;

  // Next-state logic.
  always_comb begin
    phase_nxt  = phase_r;
    units_nxt  = units_r;
    is_dah_nxt = is_dah_r;
    sq_nxt     = sq_r;
    if (tune) begin
      phase_nxt = ikey_pkg::PH_IDLE;
      units_nxt = '0;
    end else begin
      unique case (phase_r)
        ikey_pkg::PH_IDLE: begin
          if (any_press) begin
            is_dah_nxt = start_dah;
            sq_nxt     = both_press;
            units_nxt  = len - ikey_pkg::UNITS_W'(1);
            phase_nxt  = (len == ikey_pkg::UNITS_W'(1)) ? ikey_pkg::PH_SPACE
                                                         : ikey_pkg::PH_MARK;
          end else begin
            sq_nxt = 1'b0;
          end
        end
        ikey_pkg::PH_MARK: begin
          units_nxt = units_dec;
          if (units_dec == '0) begin
            phase_nxt = ikey_pkg::PH_SPACE;
          end
        end
        default: begin
          phase_nxt = ikey_pkg::PH_IDLE;
          units_nxt = '0;
        end
      endcase
    end
  end

  // Output logic.
  always_comb begin
    unique case (phase_r)
      ikey_pkg::PH_IDLE: mark = any_press;
      ikey_pkg::PH_MARK: mark = 1'b1;
      default:           mark = 1'b0;
    endcase
    key = tune | (mark & cfg.tx_enable);
    res.key_out       = key;
    res.tr_transmit   = key;
    res.sidetone_on   = tune | mark;
    res.iambic_active = ~tune & sq_nxt;
    res.qsk_restart   = keyed_r & ~key;
    keyed_nxt         = key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ikey_pkg::PH_IDLE;
      units_r  <= '0;
      is_dah_r <= 1'b0;
      sq_r     <= 1'b0;
      keyed_r  <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      units_r  <= units_nxt;
      is_dah_r <= is_dah_nxt;
      sq_r     <= sq_nxt;
      keyed_r  <= keyed_nxt;
    end
  end

endmodule

>>> hdl/ikey_out_reg.sv
// ----------------------------------------------------------------------------
// ikey_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module ikey_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ikey_pkg::result_t  load_data,
  output logic               can_load,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ikey_pkg::result_t  out_data
);

  logic              valid_r, valid_nxt;
  ikey_pkg::result_t data_r;

  // A new result may enter whenever the slot is empty or is being emptied.
  assign can_load  = ~valid_r | out_tready;
  assign valid_nxt = load | (valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_data   = data_r;

endmodule

>>> hdl/iambic_morse_keyer_top.sv
// ----------------------------------------------------------------------------
// iambic_morse_keyer_top
// Iambic Morse paddle keyer advanced by one tick request per Morse time unit.
// ----------------------------------------------------------------------------
// Each request on the in_ stream is one time-unit tick carrying the paddle
// levels, and it produces exactly one result request on the out_ stream with
// the key, sidetone, TR switch, iambic flag and QSK restart for that tick.
// The keyer state is updated in the cycle the tick is accepted and the result
// lands in an output register, so out_tvalid rises in the cycle after
// acceptance. Throughput is one tick per cycle; the only limit is the single
// result register, which accepts a new tick in the same cycle its old result
// is taken. When the receiver stalls, in_tready drops once the result register
// is full and rises again as soon as out_tready returns.
// The cfg_ channel writes the four registers (tx enable, tune mode, dit and
// dah mark lengths) by index and is always ready; unknown indexes are ignored.
// Registers are meant to be written only while no tick is in flight.
// Reset (rst_n low, synchronous) clears the sequencer to idle with the key up,
// empties the result register and loads the register defaults: tx disabled,
// tune off, one-tick dit and three-tick dah.
// ----------------------------------------------------------------------------
module iambic_morse_keyer_top (
  input  logic       clk,
  input  logic       rst_n,
  // in_tdata fields from bit 0 up: dit_pressed, dah_pressed, zero fill
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  // out_tdata fields from bit 0 up: key_out, sidetone_on, tr_transmit,
  // iambic_active, qsk_restart, zero fill
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  ikey_pkg::cfg_t    cfg_r;
  ikey_pkg::result_t res;
  ikey_pkg::result_t out_res;
  logic              can_load;
  logic              in_accept;
  logic              cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_enable <= 1'b0;
      cfg_r.tune_mode <= 1'b0;
      cfg_r.dit_units <= ikey_pkg::UNITS_W'(1);
      cfg_r.dah_units <= ikey_pkg::UNITS_W'(3);
    end else if (cfg_write) begin
      unique case (cfg_index)
        ikey_pkg::CFG_TX_ENABLE: cfg_r.tx_enable <= cfg_wdata[0];
        ikey_pkg::CFG_TUNE_MODE: cfg_r.tune_mode <= cfg_wdata[0];
        ikey_pkg::CFG_DIT_UNITS: cfg_r.dit_units <= cfg_wdata;
        ikey_pkg::CFG_DAH_UNITS: cfg_r.dah_units <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = can_load;
  assign in_accept = in_tvalid & in_tready;

  ikey_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .dit_pressed (in_tdata[0]),
    .dah_pressed (in_tdata[1]),
    .cfg         (cfg_r),
    .res         (res)
  );

  ikey_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .load_data  (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {3'b000, out_res.qsk_restart, out_res.iambic_active,
                      out_res.tr_transmit, out_res.sidetone_on, out_res.key_out};

endmodule
